FILE: src/mjs_pkg.sv
// Shared types, codes and ranking functions of the multicore job scheduler.
`timescale 1ns / 1ps
package mjs_pkg;

	localparam logic [1:0] CMD_NEW    = 2'd0;
	localparam logic [1:0] CMD_FINISH = 2'd1;
	localparam logic [1:0] CMD_EXPIRE = 2'd2;

	localparam logic [2:0] SCH_FCFS = 3'd0;
	localparam logic [2:0] SCH_SJF  = 3'd1;
	localparam logic [2:0] SCH_PSJF = 3'd2;
	localparam logic [2:0] SCH_PRI  = 3'd3;
	localparam logic [2:0] SCH_PPRI = 3'd4;
	localparam logic [2:0] SCH_RR   = 3'd5;

	localparam logic REG_SCHEME = 1'b0;
	localparam logic REG_ACTIVE = 1'b1;

	typedef struct packed {
		logic [15:0] id;
		logic [31:0] arr;
		logic [23:0] rem;
		logic [7:0]  prio;
	} job_t;

	typedef enum logic [1:0] {
		Q_NOP,
		Q_PUSH,
		Q_POP
	} q_op_t;

	typedef struct packed {
		q_op_t op;
		job_t  job;
	} q_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_PUSH_NEW,
		ST_POP,
		ST_PUSH_CUR
	} state_t;

	function automatic logic rank_gt(input logic [2:0] scheme, input job_t a, input job_t b);
		logic r;
		r = 1'b0;
		case (scheme) inside
			SCH_SJF, SCH_PSJF: r = (a.rem != b.rem) ? (a.rem > b.rem) : (a.arr > b.arr);
			SCH_PRI, SCH_PPRI: r = (a.prio != b.prio) ? (a.prio > b.prio) : (a.arr > b.arr);
			default:           r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [23:0] left_after(input logic [23:0] rem, input logic [31:0] start,
		input logic [31:0] now);
		logic [31:0] el;
		el = now - start;
		return (el >= {8'd0, rem}) ? 24'd0 : (rem - el[23:0]);
	endfunction

endpackage

FILE: src/mjs_cell.sv
// One slot of the sorted waiting queue.
`timescale 1ns / 1ps
module mjs_cell (
	input  logic          clk,
	input  logic [2:0]    scheme,
	input  mjs_pkg::q_ctl_t ctl,
	input  logic          valid,
	input  logic          left_ins,
	input  mjs_pkg::job_t left_job,
	input  mjs_pkg::job_t right_job,
	output logic          ins,
	output mjs_pkg::job_t job
);
	import mjs_pkg::*;

	job_t job_q;

	assign ins = left_ins || !valid || rank_gt(scheme, job_q, ctl.job);
	assign job = job_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			Q_PUSH: begin
				if (left_ins) begin
					job_q <= left_job;
				end else if (ins) begin
					job_q <= ctl.job;
				end
			end
			Q_POP: job_q <= right_job;
			default: job_q <= job_q;
		endcase
	end

endmodule

FILE: src/mjs_queue.sv
// Waiting queue built as a row of sorted cells with a fill count.
`timescale 1ns / 1ps
module mjs_queue #(
	parameter int QUEUE_DEPTH = 64,
	parameter int QW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [2:0]      scheme,
	input  mjs_pkg::q_ctl_t ctl,
	output mjs_pkg::job_t   head,
	output logic [QW-1:0]   count
);
	import mjs_pkg::*;

	job_t jobs [QUEUE_DEPTH];
	logic ins  [QUEUE_DEPTH];
	logic [QW-1:0] count_q;

	genvar i;
	generate
		for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
			mjs_cell u_cell (
				.clk(clk),
				.scheme(scheme),
				.ctl(ctl),
				.valid(QW'(i) < count_q),
				.left_ins((i == 0) ? 1'b0 : ins[(i == 0) ? 0 : i - 1]),
				.left_job(jobs[(i == 0) ? 0 : i - 1]),
				.right_job(jobs[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
				.ins(ins[i]),
				.job(jobs[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (ctl.op)
				Q_PUSH:  count_q <= count_q + QW'(1);
				Q_POP:   count_q <= count_q - QW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head  = jobs[0];
	assign count = count_q;

endmodule

FILE: src/multicore_job_scheduler_unit.sv
// Top level of the multicore job scheduler: core slots, control sequencer and register port.
`timescale 1ns / 1ps
// One command is taken while busy is low; its result appears on the result ports for one cycle
// with done high and cannot be held off. Its result shows in the cycle in which busy drops; a
// new job that finds every core busy under a preemptive scheme with more than one core in use
// first walks the cores one per cycle. The waiting queue is a row of sorted cells, so each
// insert or removal shifts all cells at once.
module multicore_job_scheduler_unit #(
	parameter int MAX_CORES   = 8,
	parameter int QUEUE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [15:0] job_id,
	input  logic [31:0] now,
	input  logic [23:0] run_length,
	input  logic [7:0]  job_priority,
	input  logic [2:0]  core_sel,
	output logic        done,
	output logic        scheduled,
	output logic [2:0]  core_index,
	output logic [15:0] dispatched_job,
	output logic        queue_overflow,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mjs_pkg::*;

	localparam int CW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
	localparam int NW = $clog2(MAX_CORES + 1);
	localparam int QW = $clog2(QUEUE_DEPTH + 1);

	state_t state_q, state_d;
	logic [2:0] scheme_q;
	logic [3:0] active_q;

	logic [1:0]  cmd_q;
	logic [15:0] id_q;
	logic [31:0] now_q;
	logic [23:0] len_q;
	logic [7:0]  prio_q;
	logic [2:0]  sel_q;
	logic [CW-1:0] tgt_q;
	logic exp_q, pre_q;
	logic [NW-1:0] scan_q;
	job_t worst_q, cur_q;
	logic [CW-1:0] worst_idx_q;
	logic [15:0] disp_q;

	logic [MAX_CORES-1:0] busy_q;
	job_t        core_job_q   [MAX_CORES];
	logic [31:0] core_start_q [MAX_CORES];

	logic done_q, sched_q, ovf_q;
	logic [2:0]  cidx_q;
	logic [15:0] dsp_q;

	q_ctl_t q_ctl;
	job_t   q_head;
	logic [QW-1:0] q_count;

	logic [NW-1:0] ncores;
	logic idle_found;
	logic [CW-1:0] idle_idx;
	logic [CW-1:0] rd_idx, sel_idx;
	job_t rd_job, rd_red, nj;
	logic preempt_mode, q_full, sel_ok;

	logic fin, r_sched, r_ovf;
	logic [2:0]  r_cidx;
	logic [15:0] r_disp;
	logic core_wr, busy_clr, worst_ld, tgt_ld, cur_ld, disp_ld, scan_inc;
	logic [CW-1:0] wr_idx, tgt_val;
	job_t wr_job;
	logic exp_val, pre_val;

	mjs_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .QW(QW)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.scheme(scheme_q),
		.ctl(q_ctl),
		.head(q_head),
		.count(q_count)
	);

	always_comb begin
		if (active_q == 4'd0) begin
			ncores = NW'(1);
		end else if (32'(active_q) > MAX_CORES) begin
			ncores = NW'(MAX_CORES);
		end else begin
			ncores = NW'(active_q);
		end
	end

	always_comb begin
		idle_found = 1'b0;
		idle_idx   = '0;
		for (int c = MAX_CORES - 1; c >= 0; c--) begin
			if (c < 32'(ncores) && !busy_q[c]) begin
				idle_found = 1'b1;
				idle_idx   = CW'(c);
			end
		end
	end

	assign sel_ok       = 32'(sel_q) < MAX_CORES;
	assign sel_idx      = CW'(sel_q);
	assign preempt_mode = (scheme_q == SCH_PSJF) || (scheme_q == SCH_PPRI);
	assign q_full       = q_count == QW'(QUEUE_DEPTH);
	assign nj           = '{id: id_q, arr: now_q, rem: len_q, prio: prio_q};

	always_comb begin
		unique case (state_q)
			ST_DECIDE: rd_idx = (cmd_q == CMD_NEW) ? '0 : sel_idx;
			ST_SCAN:   rd_idx = scan_q[CW-1:0];
			default:   rd_idx = tgt_q;
		endcase
	end

	always_comb begin
		rd_job     = core_job_q[rd_idx];
		rd_red     = rd_job;
		rd_red.rem = left_after(rd_job.rem, core_start_q[rd_idx], now_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_DECIDE;
			ST_DECIDE: begin
				state_d = ST_IDLE;
				unique case (cmd_q)
					CMD_NEW: begin
						if (!idle_found) begin
							if (preempt_mode && ncores != NW'(1)) begin
								state_d = ST_SCAN;
							end else begin
								state_d = ST_PUSH_NEW;
							end
						end
					end
					CMD_FINISH, CMD_EXPIRE: begin
						if (sel_ok && q_count != '0) state_d = ST_POP;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_SCAN: if (scan_q == ncores) state_d = ST_PUSH_NEW;
			ST_PUSH_NEW: begin
				if (!q_full && preempt_mode && rank_gt(scheme_q, worst_q, nj)) begin
					state_d = ST_POP;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_POP:      state_d = exp_q ? ST_PUSH_CUR : ST_IDLE;
			ST_PUSH_CUR: state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		fin      = 1'b0;
		r_sched  = 1'b0;
		r_ovf    = 1'b0;
		r_cidx   = '0;
		r_disp   = '0;
		core_wr  = 1'b0;
		busy_clr = 1'b0;
		worst_ld = 1'b0;
		tgt_ld   = 1'b0;
		cur_ld   = 1'b0;
		disp_ld  = 1'b0;
		scan_inc = 1'b0;
		wr_idx   = tgt_q;
		tgt_val  = sel_idx;
		wr_job   = nj;
		exp_val  = 1'b0;
		pre_val  = 1'b0;
		q_ctl    = '{op: Q_NOP, job: nj};
		unique case (state_q)
			ST_DECIDE: begin
				unique case (cmd_q)
					CMD_NEW: begin
						if (idle_found) begin
							core_wr = 1'b1;
							wr_idx  = idle_idx;
							fin     = 1'b1;
							r_sched = 1'b1;
							r_cidx  = 3'(idle_idx);
						end else if (preempt_mode) begin
							worst_ld = 1'b1;
						end
					end
					CMD_FINISH, CMD_EXPIRE: begin
						if (!sel_ok) begin
							fin = 1'b1;
						end else if (cmd_q == CMD_EXPIRE && busy_q[sel_idx] && q_count == '0) begin
							fin     = 1'b1;
							r_sched = 1'b1;
							r_disp  = rd_job.id;
						end else if (q_count != '0) begin
							tgt_ld  = 1'b1;
							exp_val = (cmd_q == CMD_EXPIRE) && busy_q[sel_idx];
						end else begin
							fin      = 1'b1;
							busy_clr = 1'b1;
						end
					end
					default: fin = 1'b1;
				endcase
			end
			ST_SCAN: begin
				if (scan_q != ncores) begin
					scan_inc = 1'b1;
					worst_ld = rank_gt(scheme_q, rd_red, worst_q);
				end
			end
			ST_PUSH_NEW: begin
				if (q_full) begin
					fin   = 1'b1;
					r_ovf = 1'b1;
				end else begin
					q_ctl = '{op: Q_PUSH, job: nj};
					if (preempt_mode && rank_gt(scheme_q, worst_q, nj)) begin
						tgt_ld  = 1'b1;
						tgt_val = worst_idx_q;
						exp_val = 1'b1;
						pre_val = 1'b1;
					end else begin
						fin = 1'b1;
					end
				end
			end
			ST_POP: begin
				q_ctl   = '{op: Q_POP, job: nj};
				core_wr = 1'b1;
				wr_job  = q_head;
				cur_ld  = 1'b1;
				disp_ld = 1'b1;
				if (!exp_q) begin
					fin     = 1'b1;
					r_sched = 1'b1;
					r_disp  = q_head.id;
				end
			end
			ST_PUSH_CUR: begin
				q_ctl   = '{op: Q_PUSH, job: cur_q};
				fin     = 1'b1;
				r_sched = 1'b1;
				r_cidx  = pre_q ? 3'(tgt_q) : 3'd0;
				r_disp  = pre_q ? 16'd0 : disp_q;
			end
			default: fin = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			busy_q   <= '0;
			scheme_q <= SCH_FCFS;
			active_q <= 4'd1;
			exp_q    <= 1'b0;
			pre_q    <= 1'b0;
			scan_q   <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (psel && penable && pwrite) begin
				unique case (paddr[2])
					REG_SCHEME: scheme_q <= pwdata[2:0];
					REG_ACTIVE: active_q <= pwdata[3:0];
					default:    scheme_q <= scheme_q;
				endcase
			end
			if (core_wr) busy_q[wr_idx] <= 1'b1;
			if (busy_clr) busy_q[sel_idx] <= 1'b0;
			if (state_q == ST_IDLE) begin
				exp_q <= 1'b0;
				pre_q <= 1'b0;
			end else if (tgt_ld) begin
				exp_q <= exp_val;
				pre_q <= pre_val;
			end
			if (state_q == ST_DECIDE) begin
				scan_q <= NW'(1);
			end else if (scan_inc) begin
				scan_q <= scan_q + NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q  <= command;
			id_q   <= job_id;
			now_q  <= now;
			len_q  <= run_length;
			prio_q <= job_priority;
			sel_q  <= core_sel;
		end
		if (core_wr) begin
			core_job_q[wr_idx]   <= wr_job;
			core_start_q[wr_idx] <= now_q;
		end
		if (worst_ld) begin
			worst_q     <= rd_red;
			worst_idx_q <= rd_idx;
		end
		if (tgt_ld) tgt_q <= tgt_val;
		if (cur_ld) cur_q <= rd_red;
		if (disp_ld) disp_q <= q_head.id;
		if (fin) begin
			sched_q <= r_sched;
			cidx_q  <= r_cidx;
			dsp_q   <= r_disp;
			ovf_q   <= r_ovf;
		end
	end

	assign busy           = state_q != ST_IDLE;
	assign done           = done_q;
	assign scheduled      = sched_q;
	assign core_index     = cidx_q;
	assign dispatched_job = dsp_q;
	assign queue_overflow = ovf_q;
	assign pready         = 1'b1;
	assign prdata         = (paddr[2] == REG_ACTIVE) ? {28'd0, active_q} : {29'd0, scheme_q};

`ifndef SYNTHESIS
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) != ST_IDLE) else $error("result without a command in flight");
	a_ovf_not_sched: assert property (@(posedge clk) disable iff (!arst_n)
		done && queue_overflow |-> !scheduled) else $error("dropped item reported as scheduled");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QW'(QUEUE_DEPTH)) else $error("queue count beyond depth");
	a_start_decide: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == ST_DECIDE) else $error("accepted item not decoded");
`endif

endmodule
